### rtl/core/atan2au_pkg.sv
// Shared types, constants and the arctangent table of the atan2 angle unit.
`default_nettype none

package atan2au_pkg;

  // Normalised operands have their larger magnitude in [2^NORM_TOP, 2^(NORM_TOP+1)).
  localparam int NORM_TOP = 40;
  // Datapath width: normalised magnitude, CORDIC gain of about 1.65 and sign.
  localparam int DATA_W = NORM_TOP + 5;
  // Angle accumulator counts 2^-TABLE_FRAC radian.
  localparam int TABLE_FRAC = 30;
  localparam int TABLE_LEN = 30;
  localparam int Z_W = 34;
  // Normalising shift count, up to NORM_TOP.
  localparam int SHIFT_W = 6;

  localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;

  // One item in flight through the CORDIC iterations.
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [Z_W-1:0]    z;
    logic                     y_zero;
    logic                     x_neg;
  } cordic_t;

  // atan(2^-idx) in units of 2^-30 radian, rounded to nearest.
  function automatic logic [Z_W-1:0] atan_q30(input int idx);
    case (idx)
      0:       return Z_W'(843314857);
      1:       return Z_W'(497837829);
      2:       return Z_W'(263043837);
      3:       return Z_W'(133525159);
      4:       return Z_W'(67021688);
      5:       return Z_W'(33543516);
      6:       return Z_W'(16775851);
      7:       return Z_W'(8388437);
      8:       return Z_W'(4194283);
      9:       return Z_W'(2097149);
      10:      return Z_W'(1048576);
      11:      return Z_W'(524288);
      12:      return Z_W'(262144);
      13:      return Z_W'(131072);
      14:      return Z_W'(65536);
      15:      return Z_W'(32768);
      16:      return Z_W'(16384);
      17:      return Z_W'(8192);
      18:      return Z_W'(4096);
      19:      return Z_W'(2048);
      20:      return Z_W'(1024);
      21:      return Z_W'(512);
      22:      return Z_W'(256);
      23:      return Z_W'(128);
      24:      return Z_W'(64);
      25:      return Z_W'(32);
      26:      return Z_W'(16);
      27:      return Z_W'(8);
      28:      return Z_W'(4);
      29:      return Z_W'(2);
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/core/atan2au_ifs.sv
// Valid/ready channel interfaces for the sample pair input and the angle output.
`default_nettype none

interface atan2au_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] y_sample;
  logic signed [SAMPLE_WIDTH-1:0] x_sample;

  modport source (output valid, output y_sample, output x_sample, input ready);
  modport sink (input valid, input y_sample, input x_sample, output ready);
endinterface

interface atan2au_out_if #(
  parameter int ANGLE_WIDTH = 20
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

`default_nettype wire

### rtl/core/atan2au_iter.sv
// One registered CORDIC vectoring iteration with its own valid bit and stall logic.
`default_nettype none

module atan2au_iter #(
  parameter int STAGE = 0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  v_in,
  input  atan2au_pkg::cordic_t d_in,
  output logic                 rdy_up,
  output logic                 v_out,
  output atan2au_pkg::cordic_t d_out,
  input  wire                  rdy_dn
);
  import atan2au_pkg::*;

  localparam logic signed [Z_W-1:0] ANG = atan_q30(STAGE);

  logic    v_r;
  cordic_t d_r;
  cordic_t d_nxt;

  logic signed [DATA_W-1:0] x_i;
  logic signed [DATA_W-1:0] y_i;
  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;

  // Rotate towards the x axis; the direction follows the sign of y.
  always_comb begin
    x_i   = d_in.x;
    y_i   = d_in.y;
    xs    = x_i >>> STAGE;
    ys    = y_i >>> STAGE;
    d_nxt = d_in;
    if (y_i > 0) begin
      d_nxt.x = x_i + ys;
      d_nxt.y = y_i - xs;
      d_nxt.z = d_in.z + ANG;
    end else begin
      d_nxt.x = x_i - ys;
      d_nxt.y = y_i + xs;
      d_nxt.z = d_in.z - ANG;
    end
  end

  // The slot takes a new beat when it is empty or its beat moves on.
  assign rdy_up = !v_r || rdy_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_up) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_up) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule

`default_nettype wire

### rtl/core/atan2_angle_unit.sv
// Top level of the pipelined four-quadrant CORDIC arctangent unit.
// Throughput: one sample pair per cycle while out_ch.ready does not stall the pipeline; every CORDIC
// iteration has its own register stage. Stages: input capture with magnitude compare, leading-one
// search, shift and quadrant fold, the iterations, then rounding and saturation into the output register.
// Reset clears every stage valid bit; there is no storage to clear and no clearing pass.
`default_nettype none

module atan2_angle_unit #(
  parameter int SAMPLE_WIDTH      = 24,
  parameter int ANGLE_FRAC_BITS   = 17,
  parameter int CORDIC_ITERATIONS = 18
) (
  input wire            clk,
  input wire            rst_n,
  atan2au_in_if.sink    in_ch,
  atan2au_out_if.source out_ch
);
  import atan2au_pkg::*;

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
  localparam int RND_SH  = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] HALF_LSB = Z_W'(64'sd1 <<< (RND_SH - 1));
  localparam logic signed [Z_W-1:0] PI_OUT   = (PI_Q30 + HALF_LSB) >>> RND_SH;

  // ---------------- Stage A: capture, magnitudes and their maximum ----------------
  logic                      a_v_r;
  logic signed [DATA_W-1:0]  a_x_r;
  logic signed [DATA_W-1:0]  a_y_r;
  logic [SAMPLE_WIDTH-1:0]   a_m_r;
  logic                      a_yz_r;
  logic                      a_xn_r;
  logic                      a_rdy;
  logic                      b_rdy;
  logic                      c_rdy;
  logic                      f_rdy;

  logic signed [DATA_W-1:0]  a_x_nxt;
  logic signed [DATA_W-1:0]  a_y_nxt;
  logic [DATA_W-1:0]         abs_x;
  logic [DATA_W-1:0]         abs_y;
  logic [SAMPLE_WIDTH-1:0]   a_m_nxt;

  always_comb begin
    a_x_nxt = DATA_W'(in_ch.x_sample);
    a_y_nxt = DATA_W'(in_ch.y_sample);
    abs_x   = (a_x_nxt < 0) ? DATA_W'(-a_x_nxt) : DATA_W'(a_x_nxt);
    abs_y   = (a_y_nxt < 0) ? DATA_W'(-a_y_nxt) : DATA_W'(a_y_nxt);
    a_m_nxt = (abs_x > abs_y) ? abs_x[SAMPLE_WIDTH-1:0] : abs_y[SAMPLE_WIDTH-1:0];
  end

  assign a_rdy       = !a_v_r || b_rdy;
  assign in_ch.ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_x_r  <= a_x_nxt;
      a_y_r  <= a_y_nxt;
      a_m_r  <= a_m_nxt;
      a_yz_r <= (a_y_nxt == 0);
      a_xn_r <= (a_x_nxt < 0);
    end
  end

  // ---------------- Stage B: leading-one search gives the normalising shift ----------------
  logic                      b_v_r;
  logic signed [DATA_W-1:0]  b_x_r;
  logic signed [DATA_W-1:0]  b_y_r;
  logic [SHIFT_W-1:0]        b_sh_r;
  logic [SHIFT_W-1:0]        b_sh_nxt;
  logic [SHIFT_W-1:0]        msb_idx;
  logic                      b_yz_r;
  logic                      b_xn_r;

  always_comb begin
    msb_idx = '0;
    for (int k = 0; k < SAMPLE_WIDTH; k++) begin
      if (a_m_r[k]) begin
        msb_idx = SHIFT_W'(k);
      end
    end
    b_sh_nxt = SHIFT_W'(NORM_TOP) - msb_idx;
  end

  assign b_rdy = !b_v_r || c_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_x_r  <= a_x_r;
      b_y_r  <= a_y_r;
      b_sh_r <= b_sh_nxt;
      b_yz_r <= a_yz_r;
      b_xn_r <= a_xn_r;
    end
  end

  // ---------------- Stage C: normalise and fold the left half plane ----------------
  logic                      c_v_r;
  cordic_t                   c_d_r;
  cordic_t                   c_d_nxt;
  logic signed [DATA_W-1:0]  x_sh;
  logic signed [DATA_W-1:0]  y_sh;

  always_comb begin
    x_sh            = b_x_r <<< b_sh_r;
    y_sh            = b_y_r <<< b_sh_r;
    c_d_nxt.y_zero  = b_yz_r;
    c_d_nxt.x_neg   = b_xn_r;
    if (x_sh < 0) begin
      c_d_nxt.x = -x_sh;
      c_d_nxt.y = -y_sh;
      c_d_nxt.z = (y_sh > 0) ? PI_Q30 : -PI_Q30;
    end else begin
      c_d_nxt.x = x_sh;
      c_d_nxt.y = y_sh;
      c_d_nxt.z = '0;
    end
  end

  logic    it_v   [CORDIC_ITERATIONS+1];
  cordic_t it_d   [CORDIC_ITERATIONS+1];
  logic    it_rdy [CORDIC_ITERATIONS+1];

  assign c_rdy = !c_v_r || it_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_rdy) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_d_r <= c_d_nxt;
    end
  end

  // ---------------- CORDIC iterations, one stage each ----------------
  assign it_v[0] = c_v_r;
  assign it_d[0] = c_d_r;
  assign it_rdy[CORDIC_ITERATIONS] = f_rdy;

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_iter
    atan2au_iter #(
      .STAGE(g)
    ) u_iter (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_in   (it_v[g]),
      .d_in   (it_d[g]),
      .rdy_up (it_rdy[g]),
      .v_out  (it_v[g+1]),
      .d_out  (it_d[g+1]),
      .rdy_dn (it_rdy[g+1])
    );
  end

  // ---------------- Final stage: round, saturate and special cases ----------------
  logic                      f_v_r;
  logic signed [ANGLE_W-1:0] f_angle_r;
  logic signed [ANGLE_W-1:0] f_angle_nxt;
  logic signed [Z_W-1:0]     z_rnd;
  logic signed [Z_W-1:0]     z_sat;
  cordic_t                   last_d;

  always_comb begin
    last_d = it_d[CORDIC_ITERATIONS];
    z_rnd  = (last_d.z + HALF_LSB) >>> RND_SH;
    if (z_rnd > PI_OUT) begin
      z_sat = PI_OUT;
    end else if (z_rnd < -PI_OUT) begin
      z_sat = -PI_OUT;
    end else begin
      z_sat = z_rnd;
    end
    // On the x axis the angle is exact: zero to the right, plus pi to the left.
    if (last_d.y_zero) begin
      z_sat = last_d.x_neg ? PI_OUT : '0;
    end
    f_angle_nxt = z_sat[ANGLE_W-1:0];
  end

  assign f_rdy = !f_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_rdy) begin
      f_v_r <= it_v[CORDIC_ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy) begin
      f_angle_r <= f_angle_nxt;
    end
  end

  assign out_ch.valid = f_v_r;
  assign out_ch.angle = f_angle_r;

  // ---------------- Assertions ----------------
  // An accepted beat always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> a_v_r)
    else $error("accepted beat did not reach the capture stage");

  // The normalising shift never exceeds the target exponent for a live vector.
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !b_yz_r |-> b_sh_r <= SHIFT_W'(NORM_TOP))
    else $error("normalising shift out of range");

  // After the quadrant fold the vector lies in the right half plane.
  a_fold_right: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && !c_d_r.y_zero |-> c_d_r.x >= 0)
    else $error("folded vector has negative x");

  // A delivered angle stays within plus and minus pi.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_v_r |-> (Z_W'(f_angle_r) <= PI_OUT) && (Z_W'(f_angle_r) >= -PI_OUT))
    else $error("angle beyond pi");

endmodule

`default_nettype wire
